[hdl/lbsl_pkg.sv]
// Shared types and constants of the looped breakpoint step lookup.
package lbsl_pkg;

    localparam int unsigned TIME_W  = 32;
    localparam int unsigned VALUE_W = 16;
    localparam int unsigned SEG_W   = 8;
    localparam int unsigned CFG_IW  = 2;

    typedef logic [CFG_IW-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_MODE    = 2'd0;
    localparam t_cfg_idx CFG_DEFAULT = 2'd1;
    localparam t_cfg_idx CFG_START   = 2'd2;
    localparam t_cfg_idx CFG_END     = 2'd3;

    typedef logic [1:0] t_mode;
    localparam t_mode MODE_LATCH  = 2'd0;
    localparam t_mode MODE_MOMENT = 2'd1;

    localparam logic FUNC_APPEND = 1'b0;
    localparam logic FUNC_QUERY  = 1'b1;

    typedef struct packed {
        logic                      func;
        logic [TIME_W-1:0]         time_sample;
        logic signed [VALUE_W-1:0] point_value;
    } t_in_item;

    typedef struct packed {
        logic signed [VALUE_W-1:0] level;
        logic [SEG_W-1:0]          segment_index;
        logic                      table_empty;
        logic                      range_error;
    } t_out_item;

    typedef struct packed {
        logic [TIME_W-1:0]         bp_time;
        logic signed [VALUE_W-1:0] bp_value;
    } t_entry;

endpackage

[hdl/looped_breakpoint_step_lookup.sv]
// Top level: looped breakpoint table with stepped level lookup.
// Append: the next item may follow in the next cycle.
// Query on an empty table or zero range: result valid in the cycle after transfer.
// Other queries: serial remainder, then a scan of entries (at most POINTS-1), then a
// fetch of the matched entry, or the last if none matches; input waits for the result transfer.
// Synchronous active-low reset clears count, registers and control; no memory sweep.
module looped_breakpoint_step_lookup
    import lbsl_pkg::*;
#(
    parameter int unsigned POINTS = 16
)
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  t_in_item          i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output t_out_item         o_out_data,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  t_cfg_idx          i_cfg_index,
    input  logic [TIME_W-1:0] i_cfg_data
);

    localparam int unsigned IW = (POINTS > 1) ? $clog2(POINTS) : 1;
    localparam int unsigned CW = $clog2(POINTS + 1);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_DIV   = 7'b0000010,
        S_SCAN  = 7'b0000100,
        S_CMP   = 7'b0001000,
        S_FETCH = 7'b0010000,
        S_FETW  = 7'b0100000,
        S_OUT   = 7'b1000000
    } t_state;

    t_state                    r_state, n_state;
    logic [CW-1:0]             r_count, n_count;
    t_mode                     r_mode;
    logic signed [VALUE_W-1:0] r_default;
    logic [TIME_W-1:0]         r_start;
    logic [TIME_W-1:0]         r_end;
    logic [TIME_W-1:0]         r_time, n_time;
    logic [TIME_W-1:0]         r_low, n_low;
    logic [CW-1:0]             r_ptr, n_ptr;
    logic [IW-1:0]             r_idx, n_idx;
    t_out_item                 r_out, n_out;

    logic              in_xfer;
    logic              full;
    logic [TIME_W-1:0] range;
    logic              empty;
    logic              bad_range;
    logic              div_start;
    logic              div_done;
    logic [TIME_W-1:0] div_rem;
    logic              wr_en;
    logic [IW-1:0]     wr_addr;
    t_entry            wr_data;
    logic              rd_en;
    logic [IW-1:0]     rd_addr;
    t_entry            rd_data;
    logic [CW-1:0]     ptr_prev;
    logic [CW-1:0]     last;

    assign o_in_ready  = (r_state == S_IDLE);
    assign in_xfer     = i_in_valid && o_in_ready;
    assign full        = (r_count >= CW'(POINTS));
    assign range       = r_end - r_start;
    assign empty       = (r_count == '0);
    assign bad_range   = (range == '0);
    assign div_start   = in_xfer && (i_in_data.func == FUNC_QUERY) && !empty && !bad_range;
    assign wr_en       = in_xfer && (i_in_data.func == FUNC_APPEND);
    assign wr_addr     = full ? '0 : r_count[IW-1:0];
    assign wr_data     = '{bp_time: i_in_data.time_sample, bp_value: i_in_data.point_value};
    assign ptr_prev    = r_ptr - CW'(1);
    assign last        = r_count - CW'(1);

    always_comb begin
        rd_en   = 1'b0;
        rd_addr = r_idx;
        if ((r_state == S_SCAN) && (r_ptr < r_count)) begin
            rd_en   = 1'b1;
            rd_addr = r_ptr[IW-1:0];
        end else if (r_state == S_FETCH) begin
            rd_en   = 1'b1;
        end
    end

    lbsl_divider u_divider (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (i_in_data.time_sample),
        .i_divisor  (range),
        .o_done     (div_done),
        .o_rem      (div_rem)
    );

    lbsl_table #(
        .POINTS (POINTS),
        .IW     (IW)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_time  = r_time;
        n_low   = r_low;
        n_ptr   = r_ptr;
        n_idx   = r_idx;
        n_out   = r_out;
        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    if (i_in_data.func == FUNC_APPEND) begin
                        n_count = full ? CW'(1) : r_count + CW'(1);
                    end else if (empty || bad_range) begin
                        n_out   = '{level: r_default, segment_index: '0,
                                    table_empty: empty, range_error: bad_range};
                        n_state = S_OUT;
                    end else begin
                        n_state = S_DIV;
                    end
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_time  = div_rem + r_start;
                    n_low   = '0;
                    n_ptr   = CW'(1);
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_ptr < r_count) begin
                    n_state = S_CMP;
                end else begin
                    n_idx   = last[IW-1:0];
                    n_state = S_FETCH;
                end
            end
            S_CMP: begin
                if ((r_time >= r_low) && (r_time < rd_data.bp_time)) begin
                    n_idx   = ptr_prev[IW-1:0];
                    n_state = S_FETCH;
                end else begin
                    n_low   = rd_data.bp_time;
                    n_ptr   = r_ptr + CW'(1);
                    n_state = S_SCAN;
                end
            end
            S_FETCH: begin
                n_state = S_FETW;
            end
            S_FETW: begin
                n_out.segment_index = SEG_W'(r_idx);
                n_out.table_empty   = 1'b0;
                n_out.range_error   = 1'b0;
                case (r_mode)
                    MODE_LATCH:  n_out.level = rd_data.bp_value;
                    MODE_MOMENT: n_out.level = (r_time == rd_data.bp_time) ?
                                               rd_data.bp_value : r_default;
                    default:     n_out.level = '0;
                endcase
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_mode    <= MODE_LATCH;
            r_default <= '0;
            r_start   <= '0;
            r_end     <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_MODE:    r_mode    <= i_cfg_data[1:0];
                    CFG_DEFAULT: r_default <= i_cfg_data[VALUE_W-1:0];
                    CFG_START:   r_start   <= i_cfg_data;
                    CFG_END:     r_end     <= i_cfg_data;
                    default:     ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_time <= n_time;
        r_low  <= n_low;
        r_ptr  <= n_ptr;
        r_idx  <= n_idx;
        r_out  <= n_out;
    end

    assign o_out_valid = (r_state == S_OUT);
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;

endmodule

[hdl/lbsl_divider.sv]
// Restoring remainder unit, one quotient bit per cycle.
module lbsl_divider
    import lbsl_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [TIME_W-1:0] i_dividend,
    input  logic [TIME_W-1:0] i_divisor,
    output logic              o_done,
    output logic [TIME_W-1:0] o_rem
);

    localparam int unsigned STEP_W = $clog2(TIME_W);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [TIME_W-1:0] r_rem;
    logic [TIME_W-1:0] r_dvd;
    logic [TIME_W-1:0] r_dvs;
    logic [TIME_W:0]   n_shift;
    logic [TIME_W:0]   n_diff;

    always_comb begin
        n_shift = {r_rem, r_dvd[TIME_W-1]};
        n_diff  = n_shift - {1'b0, r_dvs};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == STEP_W'(TIME_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dvd <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[TIME_W-2:0], 1'b0};
            if (!n_diff[TIME_W]) begin
                r_rem <= n_diff[TIME_W-1:0];
            end else begin
                r_rem <= n_shift[TIME_W-1:0];
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

[hdl/lbsl_table.sv]
// Breakpoint memory: one write port, one registered read port.
module lbsl_table
    import lbsl_pkg::*;
#(
    parameter int unsigned POINTS = 16,
    parameter int unsigned IW     = 4
)
(
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [IW-1:0] i_wr_addr,
    input  t_entry        i_wr_data,
    input  logic          i_rd_en,
    input  logic [IW-1:0] i_rd_addr,
    output t_entry        o_rd_data
);

    t_entry r_mem [POINTS];
    t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[hdl/lbsl_checker.sv]
// Port-level assertions for the looped breakpoint step lookup, bound to the top level.
module lbsl_checker
    import lbsl_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_ready,
    input t_in_item  i_in_data,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_item o_out_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result changed or dropped while stalled");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_in_ready)
        else $error("input taken while a result is pending");

    a_single_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready |=> !o_out_valid)
        else $error("result repeated after transfer");

    a_append_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_in_data.func == FUNC_APPEND) |=> !o_out_valid)
        else $error("append produced a result");

    a_flag_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.table_empty || o_out_data.range_error)
            |-> (o_out_data.segment_index == '0))
        else $error("flagged result with nonzero index");

endmodule

bind looped_breakpoint_step_lookup lbsl_checker u_lbsl_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
